/* sv/sapt_pkg.sv */
// shared types, codes and a helper function for the position table
`timescale 1ns / 1ps
package sapt_pkg;

    // item kinds
    typedef enum logic [1:0] {
        K_PROBE      = 2'd0,
        K_STORE      = 2'd1,
        K_NEW_SEARCH = 2'd2,
        K_CLEAR      = 2'd3
    } t_kind;

    // bound codes
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    localparam logic [30:0] MATE_THRESHOLD_RESET = 31'd30000;

    // input word
    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        key;
        logic signed [7:0]  depth;
        logic [6:0]         ply;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic signed [31:0] score;
        logic [1:0]         bound_kind;
        logic [15:0]        new_move;
    } t_in_word;

    // result word
    typedef struct packed {
        logic               hit;
        logic [15:0]        stored_move;
        logic               usable;
        logic signed [31:0] result_score;
    } t_out_word;

    // word between front and back, score already adjusted for storing
    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        key;
        logic signed [7:0]  depth;
        logic [6:0]         ply;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic signed [31:0] score;
        logic [1:0]         bound_kind;
        logic [15:0]        new_move;
    } t_mid_item;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_SWEEP,
        BK_READ,
        BK_EXEC
    } t_back_state;

    // ply adjustment near mate; into set for storing, clear for reading
    function automatic logic [31:0] mate_adjust(
        input logic signed [31:0] s,
        input logic [6:0]         ply,
        input logic               into,
        input logic [30:0]        thr
    );
        logic signed [32:0] s33;
        logic signed [32:0] t33;
        logic signed [32:0] p33;
        logic signed [32:0] r33;
        s33 = {s[31], s};
        t33 = {2'b00, thr};
        p33 = {26'd0, ply};
        if (s33 >= t33) begin
            r33 = into ? (s33 + p33) : (s33 - p33);
        end else if (s33 <= -t33) begin
            r33 = into ? (s33 - p33) : (s33 + p33);
        end else begin
            r33 = s33;
        end
        return r33[31:0];
    endfunction

endpackage

/* sv/sapt_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sapt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/sapt_fifo.sv */
// two-word queue used between the stages and for the results
`timescale 1ns / 1ps
module sapt_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, n_wp;
    logic             r_rp, n_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wp  = w_push ? !r_wp : r_wp;
        n_rp  = w_pop ? !r_rp : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

/* sv/sapt_front.sv */
// front end: takes words, works out the set and the score to store
`timescale 1ns / 1ps
module sapt_front
    import sapt_pkg::*;
#(
    parameter int SET_COUNT = 1024
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_push,
    input  t_in_word                                       i_wr_data,
    output logic                                           o_full,
    input  logic                                           i_hold,
    input  logic [30:0]                                    i_mate_threshold,
    input  logic                                           i_mid_full,
    output logic                                           o_mid_push,
    output logic [$clog2(SET_COUNT)+$bits(t_mid_item)-1:0] o_mid_data
);
    localparam int IW = $clog2(SET_COUNT);
    localparam bit POW2 = ((64'd1 << IW) == 64'(SET_COUNT));

    t_in_word         r_item;
    logic             r_busy, n_busy;
    logic             w_done;
    logic [IW-1:0]    w_index;
    logic             w_accept;
    t_mid_item        w_mid;

    assign o_mid_push = r_busy && w_done && !i_mid_full;
    assign o_full     = i_hold || (r_busy && !(w_done && !i_mid_full));
    assign w_accept   = i_push && !o_full;

    // holding register
    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (o_mid_push) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_wr_data;
        end
    end

    // set index: low key bits, or a folded remainder otherwise
    generate
        if (POW2) begin : g_pow2
            assign w_done  = 1'b1;
            assign w_index = r_item.key[IW-1:0];
        end else begin : g_fold
            localparam int XW = IW + 18;
            localparam logic [XW-1:0] SETS_X = XW'(SET_COUNT);
            // 2^16, 2^32 and 2^48 reduced by the set count
            localparam logic [XW-1:0] R16 = XW'((64'd1 << 16) % 64'(SET_COUNT));
            localparam logic [XW-1:0] R32 = XW'((64'd1 << 32) % 64'(SET_COUNT));
            localparam logic [XW-1:0] R48 = XW'((64'd1 << 48) % 64'(SET_COUNT));
            logic [XW-1:0] r_acc, n_acc;
            logic [2:0]    r_phase, n_phase;
            logic          r_done, n_done;
            logic [XW-1:0] w_fold;

            // key chunks times constants, below 2^18 times the set count
            assign w_fold = XW'(r_item.key[15:0])
                          + XW'(r_item.key[31:16]) * R16
                          + XW'(r_item.key[47:32]) * R32
                          + XW'(r_item.key[63:48]) * R48;

            // fold first, then three compare and subtract steps a cycle
            always_comb begin
                logic [XW-1:0] acc;
                int            sh;
                acc     = r_acc;
                sh      = 0;
                n_acc   = r_acc;
                n_phase = r_phase;
                n_done  = r_done;
                if (w_accept) begin
                    n_phase = 3'd0;
                    n_done  = 1'b0;
                end else if (r_busy && !r_done) begin
                    if (r_phase == 3'd0) begin
                        n_acc = w_fold;
                    end else begin
                        for (int j = 0; j < 3; j++) begin
                            sh = 3 * (6 - int'(r_phase)) + 2 - j;
                            if (acc >= (SETS_X << sh)) begin
                                acc = acc - (SETS_X << sh);
                            end
                        end
                        n_acc = acc;
                    end
                    n_phase = r_phase + 3'd1;
                    n_done  = (r_phase == 3'd6);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done  <= 1'b0;
                    r_phase <= 3'd0;
                end else begin
                    r_done  <= n_done;
                    r_phase <= n_phase;
                end
            end

            always_ff @(posedge i_clk) begin
                r_acc <= n_acc;
            end

            assign w_done  = r_done;
            assign w_index = r_acc[IW-1:0];
        end
    endgenerate

    // word for the back end
    always_comb begin
        w_mid.kind       = r_item.kind;
        w_mid.key        = r_item.key;
        w_mid.depth      = r_item.depth;
        w_mid.ply        = r_item.ply;
        w_mid.alpha      = r_item.alpha;
        w_mid.beta       = r_item.beta;
        w_mid.score      = mate_adjust(r_item.score, r_item.ply, 1'b1, i_mate_threshold);
        w_mid.bound_kind = r_item.bound_kind;
        w_mid.new_move   = r_item.new_move;
    end

    assign o_mid_data = {w_index, w_mid};
endmodule

/* sv/sapt_back.sv */
// back end: reads a set, compares the ways and writes the set back or returns a probe result
`timescale 1ns / 1ps
module sapt_back
    import sapt_pkg::*;
#(
    parameter int SET_COUNT = 1024,
    parameter int WAYS      = 4,
    parameter int MOVE_BITS = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_mid_empty,
    input  logic [$clog2(SET_COUNT)+$bits(t_mid_item)-1:0] i_mid_data,
    output logic                                           o_mid_pop,
    input  logic [30:0]                                    i_mate_threshold,
    input  logic                                           i_out_full,
    output logic                                           o_out_push,
    output t_out_word                                      o_out_data,
    output logic                                           o_sweeping
);
    localparam int IW = $clog2(SET_COUNT);
    localparam int MW = $bits(t_mid_item);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    // way layout: valid, key, score, gen, bound, depth, move
    localparam int EW = MOVE_BITS + 115;
    localparam int RW = EW * WAYS;
    localparam int O_DEPTH = MOVE_BITS;
    localparam int O_BOUND = MOVE_BITS + 8;
    localparam int O_GEN   = MOVE_BITS + 10;
    localparam int O_SCORE = MOVE_BITS + 18;
    localparam int O_KEY   = MOVE_BITS + 50;
    localparam int O_VALID = MOVE_BITS + 114;

    t_back_state   r_state, n_state;
    logic [IW-1:0] r_sweep_idx, n_sweep_idx;
    logic [7:0]    r_gen, n_gen;
    logic [IW-1:0] r_index;
    t_mid_item     r_item;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [RW-1:0] w_wdata;
    logic [RW-1:0] w_rdata;
    logic [RW-1:0] w_store_row;
    logic [EW-1:0] w_new_way;
    logic [MOVE_BITS+15:0] w_mv_ext;
    t_out_word     w_probe;

    sapt_ram #(
        .WIDTH (RW),
        .DEPTH (SET_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_mid_data[MW +: IW]),
        .o_rdata (w_rdata)
    );

    // entry written by a store
    assign w_mv_ext  = {{MOVE_BITS{1'b0}}, r_item.new_move};
    assign w_new_way = {1'b1, r_item.key, r_item.score, r_gen, r_item.bound_kind,
                        r_item.depth, w_mv_ext[MOVE_BITS-1:0]};

    // way compare: probe match and store victim
    always_comb begin
        logic [EW-1:0]        way;
        logic                 found;
        logic [EW-1:0]        sel;
        logic                 taken;
        logic                 have;
        logic [WW-1:0]        victim;
        logic signed [12:0]   best;
        logic signed [12:0]   repl;
        logic [7:0]           age;
        logic [31:0]          adj;
        logic [MOVE_BITS+15:0] mv16;
        logic [1:0]           bnd;
        found  = 1'b0;
        sel    = '0;
        taken  = 1'b0;
        have   = 1'b0;
        victim = '0;
        best   = '0;
        for (int w = 0; w < WAYS; w++) begin
            way  = w_rdata[w*EW +: EW];
            age  = r_gen - way[O_GEN +: 8];
            repl = $signed({{5{way[O_DEPTH+7]}}, way[O_DEPTH +: 8]})
                 - $signed({2'b00, age, 3'b000});
            if (!found && way[O_VALID] && (way[O_KEY +: 64] == r_item.key)) begin
                found = 1'b1;
                sel   = way;
            end
            if (!taken) begin
                if (!way[O_VALID] || (way[O_KEY +: 64] == r_item.key)) begin
                    victim = WW'(w);
                    taken  = 1'b1;
                end else if (!have || (repl < best)) begin
                    victim = WW'(w);
                    best   = repl;
                    have   = 1'b1;
                end
            end
        end
        // probe result
        adj  = mate_adjust($signed(sel[O_SCORE +: 32]), r_item.ply, 1'b0, i_mate_threshold);
        mv16 = {16'd0, sel[MOVE_BITS-1:0]};
        bnd  = sel[O_BOUND +: 2];
        w_probe.hit          = found;
        w_probe.stored_move  = found ? mv16[15:0] : 16'd0;
        w_probe.usable       = 1'b0;
        w_probe.result_score = '0;
        if (found && ($signed(sel[O_DEPTH +: 8]) >= r_item.depth)) begin
            if ((bnd == BOUND_EXACT)
                || ((bnd == BOUND_LOWER) && ($signed(adj) >= r_item.beta))
                || ((bnd == BOUND_UPPER) && ($signed(adj) <= r_item.alpha))) begin
                w_probe.usable       = 1'b1;
                w_probe.result_score = adj;
            end
        end
        // row written back for a store
        w_store_row = w_rdata;
        for (int w = 0; w < WAYS; w++) begin
            if (victim == WW'(w)) begin
                w_store_row[w*EW +: EW] = w_new_way;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_SWEEP: begin
                if (r_sweep_idx == IW'(SET_COUNT - 1)) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (!i_mid_empty && !i_out_full) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_state = (r_item.kind == K_CLEAR) ? BK_SWEEP : BK_READ;
            end
            default: begin
                n_state = BK_SWEEP;
            end
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_mid_pop   = 1'b0;
        o_out_push  = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_index;
        w_wdata     = w_store_row;
        n_sweep_idx = r_sweep_idx;
        n_gen       = r_gen;
        case (r_state)
            BK_SWEEP: begin
                w_we        = 1'b1;
                w_waddr     = r_sweep_idx;
                w_wdata     = '0;
                n_sweep_idx = r_sweep_idx + IW'(1);
            end
            BK_READ: begin
                o_mid_pop = !i_mid_empty && !i_out_full;
            end
            BK_EXEC: begin
                case (r_item.kind)
                    K_PROBE:      o_out_push = 1'b1;
                    K_STORE:      w_we = 1'b1;
                    K_NEW_SEARCH: n_gen = r_gen + 8'd1;
                    K_CLEAR: begin
                        n_gen       = 8'd0;
                        n_sweep_idx = '0;
                    end
                    default: n_gen = r_gen;
                endcase
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign o_out_data = w_probe;
    assign o_sweeping = (r_state == BK_SWEEP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_SWEEP;
            r_sweep_idx <= '0;
            r_gen       <= 8'd0;
        end else begin
            r_state     <= n_state;
            r_sweep_idx <= n_sweep_idx;
            r_gen       <= n_gen;
        end
    end

    // word in work
    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_index <= i_mid_data[MW +: IW];
            r_item  <= t_mid_item'(i_mid_data[MW-1:0]);
        end
    end
endmodule

/* sv/set_assoc_position_table.sv */
// top level of the set-associative position table
`timescale 1ns / 1ps
// Set-associative position table: WAYS ways in each of SET_COUNT sets, one set per ram row.
// The back end handles each word as a set read and then the write-back or result, and takes
// no new word before it is through with the last; when SET_COUNT is not a power of two the
// front end folds the key and then reduces it step by step before it takes the next word.
// After reset, and after each clear word, the back end sweeps all SET_COUNT rows at one
// row a cycle; full stays high for the whole sweep. Results leave through a two-word queue.
module set_assoc_position_table
    import sapt_pkg::*;
#(
    parameter int SET_COUNT = 1024,
    parameter int WAYS      = 4,
    parameter int MOVE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_in_word    i_wr_data,
    output logic        o_full,
    input  logic        i_pop,
    output t_out_word   o_rd_data,
    output logic        o_empty,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata
);
    localparam int QW = $clog2(SET_COUNT) + $bits(t_mid_item);

    logic [30:0]   r_mate_threshold;
    logic          w_mid_push, w_mid_full, w_mid_pop, w_mid_empty;
    logic [QW-1:0] w_mid_in, w_mid_out;
    logic          w_out_push, w_out_full, w_sweeping;
    t_out_word     w_out_word;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate_threshold <= MATE_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_mate_threshold <= i_cfg_wdata;
        end
    end

    sapt_front #(
        .SET_COUNT (SET_COUNT)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .i_wr_data        (i_wr_data),
        .o_full           (o_full),
        .i_hold           (w_sweeping),
        .i_mate_threshold (r_mate_threshold),
        .i_mid_full       (w_mid_full),
        .o_mid_push       (w_mid_push),
        .o_mid_data       (w_mid_in)
    );

    sapt_fifo #(
        .WIDTH (QW)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty)
    );

    sapt_back #(
        .SET_COUNT (SET_COUNT),
        .WAYS      (WAYS),
        .MOVE_BITS (MOVE_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mid_empty      (w_mid_empty),
        .i_mid_data       (w_mid_out),
        .o_mid_pop        (w_mid_pop),
        .i_mate_threshold (r_mate_threshold),
        .i_out_full       (w_out_full),
        .o_out_push       (w_out_push),
        .o_out_data       (w_out_word),
        .o_sweeping       (w_sweeping)
    );

    sapt_fifo #(
        .WIDTH ($bits(t_out_word))
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_word),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (o_rd_data),
        .o_empty (o_empty)
    );
endmodule

/* sv/sapt_checker.sv */
// port-level checks for the position table, bound to the top level
`timescale 1ns / 1ps
module sapt_checker
    import sapt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_pop,
    input logic      o_full,
    input logic      o_empty,
    input t_out_word o_rd_data
);
    // reset starts the row sweep, so no word is taken
    a_full_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_full)
        else $error("full low right after reset");

    // no result is waiting right after reset
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_empty)
        else $error("result waiting right after reset");

    // a miss carries no move and is not usable, so it carries no score
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_rd_data.hit) |->
            (o_rd_data.stored_move == 16'd0) && !o_rd_data.usable)
        else $error("miss with move or usable set");

    // score is zero unless usable
    a_score_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_rd_data.usable) |-> (o_rd_data.result_score == 32'sd0))
        else $error("score set on unusable result");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_rd_data)))
        else $error("waiting result changed");
endmodule

bind set_assoc_position_table sapt_checker u_sapt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_pop     (i_pop),
    .o_full    (o_full),
    .o_empty   (o_empty),
    .o_rd_data (o_rd_data)
);

/* tb/tb.sv */
// testbench for the set-associative position table with scoreboard and random words
`timescale 1ns / 1ps
module tb;
    import sapt_pkg::*;

    // table predictor and queue of expected result words
    class position_table_scoreboard;
        bit          slot_valid [4096];
        logic [63:0] slot_key   [4096];
        logic [31:0] slot_score [4096];
        logic [15:0] slot_move  [4096];
        logic [7:0]  slot_depth [4096];
        logic [1:0]  slot_bound [4096];
        logic [7:0]  slot_gen   [4096];
        logic [7:0]  generation;
        logic [30:0] threshold;
        t_out_word   expected_results[$];
        int          errors;

        function void clear_table();
            foreach (slot_valid[i]) slot_valid[i] = 0;
            generation = 0;
        endfunction

        // ply distance adjustment near mate, wrapped to 32 bits
        function logic [31:0] ply_adjust(logic [31:0] s, logic [6:0] ply, bit into);
            longint sv;
            longint t;
            longint r;
            sv = longint'($signed(s));
            t = longint'(threshold);
            r = sv;
            if (sv >= t) r = into ? sv + ply : sv - ply;
            else if (sv <= -t) r = into ? sv - ply : sv + ply;
            return r[31:0];
        endfunction

        function longint keep_value(int idx);
            logic [7:0] age;
            age = generation - slot_gen[idx];
            return longint'($signed(slot_depth[idx])) - 8 * longint'(age);
        endfunction

        function void note_word(t_in_word w);
            int base;
            int victim;
            bit found;
            t_out_word r;
            longint s;
            base = int'(w.key[9:0]) * 4;
            case (t_kind'(w.kind))
                K_PROBE: begin
                    r = '0;
                    for (int k = 0; k < 4; k++) begin
                        if (slot_valid[base+k] && slot_key[base+k] == w.key) begin
                            r.hit = 1;
                            r.stored_move = slot_move[base+k];
                            if ($signed(slot_depth[base+k]) >= w.depth) begin
                                r.result_score = ply_adjust(slot_score[base+k], w.ply, 0);
                                s = longint'(r.result_score);
                                if (!(slot_bound[base+k] == BOUND_EXACT
                                      || (slot_bound[base+k] == BOUND_LOWER
                                          && s >= longint'(w.beta))
                                      || (slot_bound[base+k] == BOUND_UPPER
                                          && s <= longint'(w.alpha))))
                                    r.result_score = '0;
                                else
                                    r.usable = 1;
                            end
                            break;
                        end
                    end
                    expected_results.push_back(r);
                end
                K_STORE: begin
                    victim = base;
                    found = 0;
                    for (int k = 0; k < 4; k++) begin
                        if (!slot_valid[base+k] || slot_key[base+k] == w.key) begin
                            victim = base + k;
                            break;
                        end
                        if (!found || keep_value(base+k) < keep_value(victim)) begin
                            victim = base + k;
                            found = 1;
                        end
                    end
                    slot_valid[victim] = 1;
                    slot_key[victim]   = w.key;
                    slot_score[victim] = ply_adjust(w.score, w.ply, 1);
                    slot_move[victim]  = w.new_move;
                    slot_depth[victim] = w.depth;
                    slot_bound[victim] = w.bound_kind;
                    slot_gen[victim]   = generation;
                end
                K_NEW_SEARCH: generation = generation + 8'd1;
                default: clear_table();
            endcase
        endfunction

        function void check_word(t_out_word got);
            t_out_word e;
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (got.hit !== e.hit) begin
                $error("hit expected %0d got %0d", e.hit, got.hit);
                errors++;
            end
            if (got.stored_move !== e.stored_move) begin
                $error("stored_move expected %0h got %0h", e.stored_move, got.stored_move);
                errors++;
            end
            if (got.usable !== e.usable) begin
                $error("usable expected %0d got %0d", e.usable, got.usable);
                errors++;
            end
            if (got.result_score !== e.result_score) begin
                $error("result_score expected %0d got %0d", e.result_score, got.result_score);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_push = 0;
    t_in_word    i_wr_data = '0;
    logic        o_full;
    logic        i_pop = 0;
    t_out_word   o_rd_data;
    logic        o_empty;
    logic        i_cfg_we = 0;
    logic [30:0] i_cfg_wdata = '0;

    position_table_scoreboard table_sb = new();
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          quiet_cycles;
    logic [63:0] key_pool[32];

    set_assoc_position_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_wr_data(i_wr_data),
        .o_full(o_full), .i_pop(i_pop), .o_rd_data(o_rd_data), .o_empty(o_empty),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // result side: check popped words, random stalls, watchdog
    always @(posedge i_clk) begin
        if ((i_pop && !o_empty) || (i_push && !o_full)) quiet_cycles = 0;
        else quiet_cycles++;
        if (i_pop && !o_empty) table_sb.check_word(o_rd_data);
        i_pop <= ($urandom_range(99) >= rx_idle_pct);
        if (quiet_cycles > 20000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offer one word, with random gaps before it
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_push <= 0;
            @(posedge i_clk);
        end
        i_push <= 1;
        i_wr_data <= w;
        do @(posedge i_clk); while (o_full);
        table_sb.note_word(w);
    endtask

    // drain, let any sweep finish, then write the threshold
    task automatic write_threshold(logic [30:0] v);
        i_push <= 0;
        while (table_sb.pending() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        table_sb.threshold = v;
    endtask

    function automatic t_in_word make_word(t_kind k, logic [63:0] key, logic [7:0] depth,
                                           logic [31:0] score, logic [1:0] bound);
        t_in_word w;
        w.kind = k;
        w.key = key;
        w.depth = depth;
        w.ply = 7'($urandom_range(127));
        w.alpha = $urandom;
        w.beta = $urandom;
        w.score = score;
        w.bound_kind = bound;
        w.new_move = 16'($urandom);
        return w;
    endfunction

    // score near the mate threshold or anywhere
    function automatic logic [31:0] pick_score();
        logic [31:0] t;
        t = {1'b0, table_sb.threshold};
        case ($urandom_range(5))
            0: return t + $urandom_range(3) - 1;
            1: return -t + $urandom_range(3) - 1;
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            3: return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int r;
        logic [63:0] key;
        r = $urandom_range(99);
        key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(31)];
        w = make_word(r < 47 ? K_PROBE : r < 90 ? K_STORE : r < 99 ? K_NEW_SEARCH : K_CLEAR,
                      key, 8'(($urandom_range(4) == 0) ? $urandom : $urandom_range(12) - 2),
                      pick_score(), 2'($urandom_range(3)));
        // alpha and beta from the score picks now and then
        if ($urandom_range(1)) begin
            w.alpha = pick_score();
            w.beta = pick_score();
        end
        return w;
    endfunction

    logic [30:0] thr_list[5];

    initial begin
        thr_list = '{MATE_THRESHOLD_RESET, 31'd0, 31'h7fffffff, 31'd100, 31'd0};
        thr_list[4] = 31'($urandom);
        for (int i = 0; i < 32; i++)
            key_pool[i] = {$urandom, 22'($urandom), 10'(i % 4 == 3 ? 1023 : i % 4)};
        table_sb.clear_table();
        table_sb.threshold = MATE_THRESHOLD_RESET;
        table_sb.errors = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        for (int ph = 0; ph < 5; ph++) begin
            tx_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 88 : 0;
            rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 20 : 0;
            write_threshold(thr_list[ph]);
            if (ph == 0) begin
                // directed: extremes, full set eviction, bound codes, clear
                send_word(make_word(K_PROBE, 64'h0, 8'h80, 0, BOUND_EXACT));
                send_word(make_word(K_STORE, 64'h0, 8'h7f, 32'd30000, BOUND_EXACT));
                send_word(make_word(K_STORE, '1, 8'h80, -32'sd30000, BOUND_LOWER));
                send_word(make_word(K_PROBE, 64'h0, 8'h7f, 0, BOUND_EXACT));
                send_word(make_word(K_PROBE, '1, 8'h80, 0, BOUND_EXACT));
                send_word(make_word(K_STORE, 64'h400, 8'd3, 32'h7fffffff, BOUND_UPPER));
                send_word(make_word(K_STORE, 64'h800, 8'd5, 32'h80000000, 2'd3));
                send_word(make_word(K_NEW_SEARCH, 64'h0, 8'd0, 0, BOUND_EXACT));
                send_word(make_word(K_STORE, 64'hc00, 8'd1, 32'd29999, BOUND_EXACT));
                send_word(make_word(K_STORE, 64'h1000, 8'd2, -32'sd29999, BOUND_LOWER));
                send_word(make_word(K_PROBE, 64'h400, 8'd0, 0, BOUND_EXACT));
                send_word(make_word(K_PROBE, 64'h800, 8'h80, 0, BOUND_EXACT));
                send_word(make_word(K_PROBE, 64'h1000, 8'd2, 0, BOUND_EXACT));
                send_word(make_word(K_PROBE, 64'hc00, 8'd2, 0, BOUND_EXACT));
                send_word(make_word(K_CLEAR, 64'h0, 8'd0, 0, BOUND_EXACT));
                send_word(make_word(K_PROBE, 64'h0, 8'h80, 0, BOUND_EXACT));
            end
            // generation wrap
            if (ph == 2)
                for (int i = 0; i < 260; i++)
                    send_word(make_word(K_NEW_SEARCH, {$urandom, $urandom}, 8'd0, 0,
                                        BOUND_EXACT));
            for (int i = 0; i < 150; i++) begin
                if (ph == 3 && i == 100) begin
                    i_push <= 0;
                    @(posedge i_clk);
                    while (table_sb.pending() != 0) @(posedge i_clk);
                end
                send_word(random_word());
            end
        end
        i_push <= 0;
        while (table_sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (table_sb.errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
